// File: src/itvc_pkg.sv
// Shared types, constants and the built-in interval table of the vote classifier.
package itvc_pkg;

   localparam int NUM_CLASSES = 4;
   localparam int NUM_CHANNELS = 4;
   localparam int MAX_SAMPLES = 64;

   localparam int NUM_IN_CHANNELS = 4;
   localparam int SAMPLE_W = 8;
   localparam int BOUND_W = 10;
   localparam int BIDX_W = 5;
   localparam int SCORE_W = 9;
   localparam int SC_W = 7;
   localparam int THR_W = 9;
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 9;
   localparam int TABLE_SIZE = NUM_CLASSES * NUM_CHANNELS * 2;
   localparam int TIDX_W = $clog2(TABLE_SIZE);
   localparam int HIT_W = $clog2(NUM_CHANNELS + 1);
   localparam int CAPT_W = $clog2(MAX_SAMPLES + 1);
   localparam int CLS_W = $clog2(NUM_CLASSES + 1);

   localparam logic [SCORE_W-1:0] SCORE_MAX = '1;
   localparam logic [SC_W-1:0] SAMPLE_COUNT_RESET = 7'd10;
   localparam logic [THR_W-1:0] MATCH_THRESHOLD_RESET = 9'd32;

   localparam logic [CSR_ADDR_W-1:0] REG_SAMPLE_COUNT = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_MATCH_THRESHOLD = 1'd1;

   localparam logic [7:0] START_BUTTONS = 8'h11;
   localparam logic [7:0] SEL_CHANNEL_0 = 8'h80;
   localparam logic [7:0] SEL_CHANNEL_1 = 8'h40;
   localparam logic [7:0] SEL_CHANNEL_2 = 8'h20;
   localparam logic [7:0] SEL_CHANNEL_3 = 8'h10;
   localparam logic [3:0] NONE_DIGIT_HIGH = 4'hE;
   localparam logic [7:0] NONE_DIGIT_LOW = 8'hE0;
   localparam logic [2:0] DOT_ON = 3'd4;
   localparam logic [2:0] DOT_OFF = 3'd0;

   localparam logic [3:0] EV_NOTHING = 4'd0;
   localparam logic [3:0] EV_START = 4'd1;
   localparam logic [3:0] EV_SAMPLE = 4'd2;
   localparam logic [3:0] EV_STOP = 4'd3;
   localparam logic [3:0] EV_NONE = 4'd8;

   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_CAPTURE = 2'd1,
      PH_VERIFY  = 2'd2
   } phase_type;

   typedef struct packed {
      logic                                      mode;
      logic [7:0]                                buttons;
      logic [7:0]                                switches;
      logic [NUM_IN_CHANNELS-1:0][SAMPLE_W-1:0]  channel;
      logic [BIDX_W-1:0]                         bound_index;
      logic [BOUND_W-1:0]                        bound_value;
   } item_type;

   typedef struct packed {
      logic [2:0] dot_mask;
      logic [7:0] digit_low;
      logic [3:0] digit_high;
      logic [7:0] led;
      logic [3:0] event_res;
   } result_type;

   typedef logic [NUM_CLASSES-1:0][HIT_W-1:0] hits_type;
   typedef logic [NUM_CLASSES-1:0][SCORE_W-1:0] scores_type;

   localparam logic [BOUND_W-1:0] DEFAULT_BOUNDS [32] = '{
      10'd60,  10'd90,  10'd520, 10'd610, 10'd20,  10'd60,  10'd90,  10'd170,
      10'd180, 10'd270, 10'd60,  10'd100, 10'd300, 10'd530, 10'd130, 10'd240,
      10'd550, 10'd830, 10'd180, 10'd280, 10'd240, 10'd390, 10'd40,  10'd110,
      10'd500, 10'd780, 10'd0,   10'd60,  10'd430, 10'd615, 10'd585, 10'd810
   };

   function automatic logic [BOUND_W-1:0] default_bound(input int i);
      int k;
      int rest;
      int c;
      k = i / (NUM_CHANNELS * 2);
      rest = i % (NUM_CHANNELS * 2);
      c = rest / 2;
      if (k < 4 && c < 4) begin
         return DEFAULT_BOUNDS[k * 8 + rest];
      end
      return '0;
   endfunction

endpackage

// File: src/itvc_bounds.sv
// Interval bound register file and the parallel per-class range compares.
module itvc_bounds (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  itvc_pkg::item_type  item,
   output itvc_pkg::hits_type  hits
);
   import itvc_pkg::*;

   logic [BOUND_W-1:0] bounds_ff [TABLE_SIZE];
   logic [NUM_CHANNELS-1:0][SAMPLE_W-1:0] sample;
   logic wr_en;

   for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_sample
      if (c < NUM_IN_CHANNELS) begin : g_live
         assign sample[c] = item.channel[c];
      end else begin : g_zero
         assign sample[c] = '0;
      end
   end

   assign wr_en = step && item.mode && (32'(item.bound_index) < TABLE_SIZE);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_SIZE; i++) begin
            bounds_ff[i] <= default_bound(i);
         end
      end else if (wr_en) begin
         bounds_ff[TIDX_W'(item.bound_index)] <= item.bound_value;
      end
   end

   always_comb begin
      logic [BOUND_W-1:0] scaled;
      logic [BOUND_W-1:0] lo;
      logic [BOUND_W-1:0] hi;
      hits = '0;
      for (int k = 0; k < NUM_CLASSES; k++) begin
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            scaled = {sample[c], 2'b00};
            lo = bounds_ff[(k * NUM_CHANNELS + c) * 2];
            hi = bounds_ff[(k * NUM_CHANNELS + c) * 2 + 1];
            if (scaled >= lo && scaled <= hi) begin
               hits[k] = hits[k] + HIT_W'(1);
            end
         end
      end
   end

endmodule

// File: src/itvc_ctrl.sv
// Capture sequencer, class scores, election and display result of the vote classifier.
module itvc_ctrl (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [itvc_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [itvc_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                step,
   input  itvc_pkg::item_type                  item,
   input  itvc_pkg::hits_type                  hits,
   output itvc_pkg::result_type                result
);
   import itvc_pkg::*;

   phase_type          phase_ff, phase_in;
   logic [CAPT_W-1:0]  captured_ff, captured_in;
   scores_type         scores_ff, scores_in;
   logic [SC_W-1:0]    sample_count_ff;
   logic [THR_W-1:0]   match_threshold_ff;

   logic               poll;
   logic               start_req;
   logic               capture_more;
   logic [SCORE_W-1:0] best;
   logic [CLS_W-1:0]   num;

   assign poll = step && !item.mode;
   assign start_req = (item.buttons == START_BUTTONS) && (item.switches == 8'h00);
   assign capture_more = (32'(captured_ff) < 32'(sample_count_ff)) &&
                         (32'(captured_ff) < MAX_SAMPLES);

   always_comb begin
      best = '0;
      num = '0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
         if (scores_ff[i] >= best) begin
            best = scores_ff[i];
            num = CLS_W'(i + 1);
         end
      end
   end

   always_comb begin
      phase_in = phase_ff;
      if (poll) begin
         case (phase_ff)
            PH_IDLE: begin
               if (start_req) phase_in = PH_CAPTURE;
            end
            PH_CAPTURE: begin
               if (!capture_more) phase_in = PH_VERIFY;
            end
            PH_VERIFY: phase_in = PH_IDLE;
            default: phase_in = PH_IDLE;
         endcase
      end
   end

   always_comb begin
      logic [SCORE_W:0] sum;
      captured_in = captured_ff;
      scores_in = scores_ff;
      sum = '0;
      if (poll && phase_ff == PH_CAPTURE && capture_more) begin
         captured_in = captured_ff + CAPT_W'(1);
         for (int k = 0; k < NUM_CLASSES; k++) begin
            sum = {1'b0, scores_ff[k]} + (SCORE_W + 1)'(hits[k]);
            scores_in[k] = (sum > {1'b0, SCORE_MAX}) ? SCORE_MAX : sum[SCORE_W-1:0];
         end
      end else if (poll && phase_ff == PH_VERIFY) begin
         captured_in = '0;
         scores_in = '0;
      end
   end

   always_comb begin
      result = '0;
      if (!item.mode) begin
         result.led = item.switches;
         case (item.switches)
            SEL_CHANNEL_0: begin
               result.digit_high = 4'd1;
               result.digit_low = item.channel[0];
               result.dot_mask = DOT_ON;
            end
            SEL_CHANNEL_1: begin
               result.digit_high = 4'd2;
               result.digit_low = item.channel[1];
               result.dot_mask = DOT_ON;
            end
            SEL_CHANNEL_2: begin
               result.digit_high = 4'd3;
               result.digit_low = item.channel[2];
               result.dot_mask = DOT_ON;
            end
            SEL_CHANNEL_3: begin
               result.digit_high = 4'd4;
               result.digit_low = item.channel[3];
               result.dot_mask = DOT_ON;
            end
            default: result.dot_mask = DOT_OFF;
         endcase
         case (phase_ff)
            PH_IDLE: begin
               result.event_res = start_req ? EV_START : EV_NOTHING;
            end
            PH_CAPTURE: begin
               result.event_res = capture_more ? EV_SAMPLE : EV_STOP;
            end
            PH_VERIFY: begin
               if (num != '0 && 32'(best) >= 32'(match_threshold_ff)) begin
                  result.event_res = EV_STOP + 4'(num);
                  result.digit_high = 4'(num);
                  result.digit_low = (32'(best) > 255) ? 8'hFF : best[7:0];
                  result.dot_mask = DOT_ON;
               end else begin
                  result.event_res = EV_NONE;
                  result.digit_high = NONE_DIGIT_HIGH;
                  result.digit_low = NONE_DIGIT_LOW;
                  result.dot_mask = DOT_OFF;
               end
            end
            default: result.event_res = EV_NOTHING;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         captured_ff <= '0;
         scores_ff <= '0;
         sample_count_ff <= SAMPLE_COUNT_RESET;
         match_threshold_ff <= MATCH_THRESHOLD_RESET;
      end else begin
         phase_ff <= phase_in;
         captured_ff <= captured_in;
         scores_ff <= scores_in;
         if (csr_we && csr_addr == REG_SAMPLE_COUNT) begin
            sample_count_ff <= csr_wdata[SC_W-1:0];
         end
         if (csr_we && csr_addr == REG_MATCH_THRESHOLD) begin
            match_threshold_ff <= csr_wdata[THR_W-1:0];
         end
      end
   end

   a_idle_scores_clear: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> scores_ff == '0)
      else $error("Class scores are not clear while idle.");

   a_captured_bounded: assert property (@(posedge clock) disable iff (reset)
      32'(captured_ff) <= MAX_SAMPLES)
      else $error("Capture count passed its limit.");

   a_sample_counts: assert property (@(posedge clock) disable iff (reset)
      poll && phase_ff == PH_CAPTURE && capture_more
      |=> captured_ff == $past(captured_ff) + CAPT_W'(1))
      else $error("A sampled poll did not advance the capture count.");

   a_verify_resets: assert property (@(posedge clock) disable iff (reset)
      poll && phase_ff == PH_VERIFY |=> phase_ff == PH_IDLE && captured_ff == '0)
      else $error("Election did not return the sequencer to idle.");

endmodule

// File: src/interval_template_vote_classifier.sv
// Top level of the interval template vote classifier: input stage, output register and core.
//
//   Channel  Direction  Beat content
//   req_     in         tuser: mode; tdata: buttons, switches, channel_0..3,
//                       bound_index, bound_value
//   rsp_     out        tdata: event_res, led, digit_high, digit_low, dot_mask
//   csr_     in         write enable, register index, write data
//
// One beat is accepted every cycle unless the output stalls; results leave from the output register.
// The range compares and score update run between the input and output registers.
// Reset is synchronous; it reloads the built-in bound table and clears scores at once.
// A stalled result holds in the output register while one more beat waits in the input stage.
module interval_template_vote_classifier (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // buttons, switches, channel_0..3, bound_index, bound_value
   input  logic        req_tuser,   // mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // event_res, led, digit_high, digit_low, dot_mask
   input  logic        csr_we,
   input  logic [itvc_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [itvc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import itvc_pkg::*;

   item_type   item_ff;
   item_type   item_in;
   logic       item_valid_ff, item_valid_in;
   result_type rsp_ff;
   result_type result;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       step;
   logic       accept;
   hits_type   hits;

   assign step = item_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !item_valid_ff || step;
   assign accept = req_tvalid && req_tready;

   always_comb begin
      item_in.mode = req_tuser;
      item_in.buttons = req_tdata[7:0];
      item_in.switches = req_tdata[15:8];
      item_in.channel[0] = req_tdata[23:16];
      item_in.channel[1] = req_tdata[31:24];
      item_in.channel[2] = req_tdata[39:32];
      item_in.channel[3] = req_tdata[47:40];
      item_in.bound_index = req_tdata[52:48];
      item_in.bound_value = req_tdata[62:53];
   end

   always_comb begin
      item_valid_in = item_valid_ff;
      if (accept) begin
         item_valid_in = 1'b1;
      end else if (step) begin
         item_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
      if (step) begin
         rsp_ff <= result;
      end
   end

   itvc_bounds u_bounds (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .item  (item_ff),
      .hits  (hits)
   );

   itvc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .step      (step),
      .item      (item_ff),
      .hits      (hits),
      .result    (result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {5'b0, rsp_ff.dot_mask, rsp_ff.digit_low, rsp_ff.digit_high,
                       rsp_ff.led, rsp_ff.event_res};

endmodule

// File: tb/vote_check_pkg.sv
// Scoreboard class that predicts and checks the vote classifier's result beats.
package vote_check_pkg;
   import itvc_pkg::*;

   class vote_scoreboard;
      logic [SC_W-1:0]    sample_count;
      logic [THR_W-1:0]   match_threshold;
      phase_type          phase;
      int                 captured;
      int                 scores [NUM_CLASSES];
      logic [BOUND_W-1:0] bounds [TABLE_SIZE];
      result_type         pending_displays [$];
      int                 errors;

      function new();
         sample_count = SAMPLE_COUNT_RESET;
         match_threshold = MATCH_THRESHOLD_RESET;
         phase = PH_IDLE;
         captured = 0;
         errors = 0;
         foreach (scores[k]) scores[k] = 0;
         foreach (bounds[i]) bounds[i] = DEFAULT_BOUNDS[i];
      endfunction

      function void write_reg(logic [CSR_ADDR_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         if (idx == REG_SAMPLE_COUNT) begin
            sample_count = value[SC_W-1:0];
         end else if (idx == REG_MATCH_THRESHOLD) begin
            match_threshold = value[THR_W-1:0];
         end
      endfunction

      function int capture_length();
         return (sample_count > MAX_SAMPLES) ? MAX_SAMPLES : int'(sample_count);
      endfunction

      // Works out the display and event of one accepted request beat.
      function void note_beat(logic mode, logic [63:0] data);
         logic [7:0]          buttons;
         logic [7:0]          switches;
         logic [SAMPLE_W-1:0] chan [NUM_IN_CHANNELS];
         logic [BIDX_W-1:0]   bidx;
         logic [BOUND_W-1:0]  bval;
         result_type          r;
         int                  best;
         int                  winner;
         int                  scaled;
         int                  base;
         buttons = data[7:0];
         switches = data[15:8];
         for (int c = 0; c < NUM_IN_CHANNELS; c++) chan[c] = data[16 + 8 * c +: 8];
         bidx = data[52:48];
         bval = data[62:53];
         r = '0;
         if (mode) begin
            bounds[bidx] = bval;
            pending_displays.push_back(r);
            return;
         end
         r.led = switches;
         case (switches)
            SEL_CHANNEL_0: begin
               r.digit_high = 4'd1;
               r.digit_low = chan[0];
               r.dot_mask = DOT_ON;
            end
            SEL_CHANNEL_1: begin
               r.digit_high = 4'd2;
               r.digit_low = chan[1];
               r.dot_mask = DOT_ON;
            end
            SEL_CHANNEL_2: begin
               r.digit_high = 4'd3;
               r.digit_low = chan[2];
               r.dot_mask = DOT_ON;
            end
            SEL_CHANNEL_3: begin
               r.digit_high = 4'd4;
               r.digit_low = chan[3];
               r.dot_mask = DOT_ON;
            end
            default: ;
         endcase
         case (phase)
            PH_IDLE: begin
               if (buttons == START_BUTTONS && switches == 8'h00) begin
                  phase = PH_CAPTURE;
                  r.event_res = EV_START;
               end
            end
            PH_CAPTURE: begin
               if (captured < capture_length()) begin
                  for (int c = 0; c < NUM_CHANNELS; c++) begin
                     scaled = (c < NUM_IN_CHANNELS) ? int'(chan[c]) * 4 : 0;
                     for (int k = 0; k < NUM_CLASSES; k++) begin
                        base = (k * NUM_CHANNELS + c) * 2;
                        if (scaled >= bounds[base] && scaled <= bounds[base + 1]
                            && scores[k] < SCORE_MAX) begin
                           scores[k]++;
                        end
                     end
                  end
                  captured++;
                  r.event_res = EV_SAMPLE;
               end else begin
                  phase = PH_VERIFY;
                  r.event_res = EV_STOP;
               end
            end
            PH_VERIFY: begin
               // Ties go to the higher class index.
               best = 0;
               winner = 0;
               for (int k = 0; k < NUM_CLASSES; k++) begin
                  if (scores[k] >= best) begin
                     best = scores[k];
                     winner = k + 1;
                  end
               end
               if (winner != 0 && best >= match_threshold) begin
                  r.event_res = EV_STOP + 4'(winner);
                  r.digit_high = 4'(winner);
                  r.digit_low = (best > 255) ? 8'hFF : 8'(best);
                  r.dot_mask = DOT_ON;
               end else begin
                  r.event_res = EV_NONE;
                  r.digit_high = NONE_DIGIT_HIGH;
                  r.digit_low = NONE_DIGIT_LOW;
                  r.dot_mask = DOT_OFF;
               end
               foreach (scores[k]) scores[k] = 0;
               captured = 0;
               phase = PH_IDLE;
            end
            default: phase = PH_IDLE;
         endcase
         pending_displays.push_back(r);
      endfunction

      function void compare_field(string name, int want, int got);
         if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_result(logic [31:0] data);
         result_type want;
         if (pending_displays.size() == 0) begin
            $error("result beat 0x%h arrived with no prediction waiting", data);
            errors++;
            return;
         end
         want = pending_displays.pop_front();
         compare_field("event_res", want.event_res, data[3:0]);
         compare_field("led", want.led, data[11:4]);
         compare_field("digit_high", want.digit_high, data[15:12]);
         compare_field("digit_low", want.digit_low, data[23:16]);
         compare_field("dot_mask", want.dot_mask, data[26:24]);
      endfunction
   endclass

endpackage

// File: tb/interval_template_vote_classifier_tb.sv
// Testbench top: drives polls, bound loads and register writes and checks every result beat.
module interval_template_vote_classifier_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import itvc_pkg::*;
   import vote_check_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 4;
   localparam int BEATS_PER_PHASE = 420;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [63:0]           req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [31:0]           rsp_tdata;
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int stall_left = 0;
   int beats_sent = 0;

   vote_scoreboard sb = new();

   interval_template_vote_classifier u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we) sb.write_reg(csr_addr, csr_wdata);
         if (req_tvalid && req_tready) sb.note_beat(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
      end
   end

   // The receiver either serves a requested hold-off or stalls at random.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_tready = 1'b0;
            stall_left--;
         end else begin
            rsp_tready = ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   initial begin
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("interval_template_vote_classifier_tb failed");
      $finish;
   end

   task automatic send_beat(item_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tuser = it.mode;
      req_tdata = {1'b0, it.bound_value, it.bound_index, it.channel, it.switches, it.buttons};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      req_tvalid = 1'b0;
      beats_sent++;
   endtask

   task automatic write_csr(logic [CSR_ADDR_W-1:0] idx, int value);
      csr_we = 1'b1;
      csr_addr = idx;
      csr_wdata = CSR_DATA_W'(value);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic wait_for_results();
      while (sb.pending_displays.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic logic [7:0] any_switches();
      case ($urandom_range(9))
         0: return SEL_CHANNEL_0;
         1: return SEL_CHANNEL_1;
         2: return SEL_CHANNEL_2;
         3: return SEL_CHANNEL_3;
         4: return 8'h00;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic item_type bound_load();
      item_type it;
      it.mode = 1'b1;
      it.buttons = 8'($urandom);
      it.switches = 8'($urandom);
      it.channel = 32'($urandom);
      it.bound_index = BIDX_W'($urandom);
      it.bound_value = $urandom_range(1) ? DEFAULT_BOUNDS[it.bound_index] : BOUND_W'($urandom);
      return it;
   endfunction

   // Samples aimed at class cls fall inside its interval with probability hit_pct.
   function automatic item_type poll(logic [7:0] buttons, logic [7:0] switches, int cls,
                                     int hit_pct);
      item_type it;
      int lo;
      int hi;
      int base;
      it.mode = 1'b0;
      it.buttons = buttons;
      it.switches = switches;
      it.bound_index = BIDX_W'($urandom);
      it.bound_value = BOUND_W'($urandom);
      for (int c = 0; c < NUM_IN_CHANNELS; c++) begin
         it.channel[c] = SAMPLE_W'($urandom);
         if (cls < NUM_CLASSES && $urandom_range(99) < hit_pct) begin
            base = (cls * NUM_CHANNELS + c) * 2;
            lo = (int'(sb.bounds[base]) + 3) / 4;
            hi = int'(sb.bounds[base + 1]) / 4;
            if (hi > 255) hi = 255;
            if (lo <= hi) it.channel[c] = SAMPLE_W'($urandom_range(hi, lo));
         end
      end
      return it;
   endfunction

   task automatic run_recognition(int cls, int hit_pct, bit hold);
      int length;
      logic [7:0] btn;
      logic [7:0] sw;
      length = sb.capture_length();
      repeat ($urandom_range(2)) begin
         if ($urandom_range(1)) begin
            send_beat(bound_load());
         end else begin
            btn = 8'($urandom);
            sw = any_switches();
            if (btn == START_BUTTONS && sw == 8'h00) sw = SEL_CHANNEL_0;
            send_beat(poll(btn, sw, NUM_CLASSES, 0));
         end
      end
      if (hold) begin
         @(posedge clock);
         stall_left = 60;
         @(negedge clock);
      end
      send_beat(poll(START_BUTTONS, 8'h00, cls, hit_pct));
      for (int i = 0; i < length; i++) begin
         if ($urandom_range(9) == 0) send_beat(bound_load());
         btn = ($urandom_range(9) == 0) ? START_BUTTONS : 8'($urandom);
         sw = (btn == START_BUTTONS) ? 8'h00 : any_switches();
         send_beat(poll(btn, sw, cls, hit_pct));
      end
      send_beat(poll(8'($urandom), any_switches(), NUM_CLASSES, 0));
      if ($urandom_range(3) == 0) begin
         send_beat(poll(START_BUTTONS, 8'h00, NUM_CLASSES, 0));
      end else begin
         send_beat(poll(8'($urandom), any_switches(), NUM_CLASSES, 0));
      end
   endtask

   initial begin
      item_type it;
      int sc;
      int eff;
      int thr;
      int reps;
      int stop_at;
      int hit;
      bit first;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      csr_we = 1'b0;
      csr_addr = '0;
      csr_wdata = '0;
      send_idle_pct = 19;
      recv_idle_pct = 67;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Display selection, sample extremes and bound loads at the table ends.
      it = poll(8'h00, SEL_CHANNEL_0, NUM_CLASSES, 0);
      it.channel = {8'h00, 8'h00, 8'h00, 8'hFF};
      send_beat(it);
      it = poll(8'h00, SEL_CHANNEL_1, NUM_CLASSES, 0);
      it.channel = {8'h01, 8'h80, 8'hFF, 8'h00};
      send_beat(it);
      it = poll(8'h00, SEL_CHANNEL_2, NUM_CLASSES, 0);
      it.channel = {8'h00, 8'hFF, 8'h00, 8'hFF};
      send_beat(it);
      it = poll(8'h00, SEL_CHANNEL_3, NUM_CLASSES, 0);
      it.channel = {8'hFF, 8'h00, 8'h00, 8'h00};
      send_beat(it);
      it = poll(8'hFF, 8'hFF, NUM_CLASSES, 0);
      it.channel = '1;
      send_beat(it);
      it = poll(8'h00, 8'h00, NUM_CLASSES, 0);
      it.channel = '0;
      send_beat(it);
      send_beat(poll(START_BUTTONS, SEL_CHANNEL_0, NUM_CLASSES, 0));
      it = bound_load();
      it.bound_index = 5'd31;
      it.bound_value = 10'h3FF;
      send_beat(it);
      it = bound_load();
      it.bound_index = 5'd0;
      it.bound_value = 10'h000;
      send_beat(it);

      // An empty capture elects the highest class on an all-zero tie.
      wait_for_results();
      write_csr(REG_SAMPLE_COUNT, 0);
      write_csr(REG_MATCH_THRESHOLD, 0);
      repeat (3) send_beat(poll(START_BUTTONS, 8'h00, NUM_CLASSES, 0));

      // A start press during capture is ignored, and an unreachable threshold gives none.
      wait_for_results();
      write_csr(REG_SAMPLE_COUNT, 2);
      write_csr(REG_MATCH_THRESHOLD, 511);
      repeat (5) send_beat(poll(START_BUTTONS, 8'h00, 0, 100));

      // Lowering the capture length mid-capture stops it on the next poll.
      wait_for_results();
      write_csr(REG_SAMPLE_COUNT, 3);
      repeat (3) send_beat(poll(START_BUTTONS, 8'h00, 1, 80));
      wait_for_results();
      write_csr(REG_SAMPLE_COUNT, 1);
      send_beat(poll(8'h00, SEL_CHANNEL_2, 1, 80));
      send_beat(poll(8'h00, SEL_CHANNEL_3, NUM_CLASSES, 0));

      // A full-length capture that hits on every channel pushes a score past 255.
      wait_for_results();
      write_csr(REG_SAMPLE_COUNT, 127);
      write_csr(REG_MATCH_THRESHOLD, 256);
      run_recognition(0, 100, 1'b0);

      for (int p = 0; p < 3; p++) begin
         case (p)
            0: begin
               send_idle_pct = 19;
               recv_idle_pct = 67;
            end
            1: begin
               send_idle_pct = 67;
               recv_idle_pct = 19;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         stop_at = beats_sent + BEATS_PER_PHASE;
         first = 1'b1;
         while (beats_sent < stop_at) begin
            wait_for_results();
            case ($urandom_range(15))
               0: sc = 0;
               1: sc = 1;
               2: sc = $urandom_range(1) ? MAX_SAMPLES : 127;
               default: sc = $urandom_range(12, 2);
            endcase
            eff = (sc > MAX_SAMPLES) ? MAX_SAMPLES : sc;
            case ($urandom_range(7))
               0: thr = 0;
               1: thr = 511;
               2: thr = $urandom_range(511);
               default: thr = $urandom_range(eff * 4);
            endcase
            write_csr(REG_SAMPLE_COUNT, sc);
            write_csr(REG_MATCH_THRESHOLD, thr);
            reps = (eff >= 32) ? 1 : $urandom_range(3, 1);
            repeat (reps) begin
               case ($urandom_range(2))
                  0: hit = 100;
                  1: hit = 80;
                  default: hit = 40;
               endcase
               run_recognition($urandom_range(NUM_CLASSES), hit, first && p != 1);
               first = 1'b0;
            end
         end
      end

      wait_for_results();
      repeat (8) @(negedge clock);
      if (sb.errors == 0) begin
         $display("interval_template_vote_classifier_tb passed");
      end else begin
         $display("interval_template_vote_classifier_tb failed");
      end
      $finish;
   end

endmodule

// File: filelist.f
src/itvc_pkg.sv
src/itvc_bounds.sv
src/itvc_ctrl.sv
src/interval_template_vote_classifier.sv
tb/vote_check_pkg.sv
tb/interval_template_vote_classifier_tb.sv
